// File: src/sha_pkg.sv
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_init;    // Chaining value returns to the IV.
    logic start_round;  // Copy chaining value into working variables.
    logic round_en;     // Run one round at round index.
    logic [5:0] round;  // Current round.
    logic fold;         // Add working variables into chaining value.
    logic shift_out;    // Rotate chaining value by one word toward H0.
  } sha_cmd_t;

  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// File: src/sha_datapath.sv
module sha_datapath (
  input  logic             clk,
  input  sha_pkg::sha_cmd_t cmd,
  input  sha_pkg::word_t   win,     // Next message word for rounds 0 to 15.
  output sha_pkg::word_t   h0       // Current H0, the digest word on output.
);

  sha_pkg::word_t hv [8];
  sha_pkg::word_t wv [8];
  sha_pkg::word_t sw [16];
  sha_pkg::word_t w, t1, t2, s0, s1, e, a;

  always_comb begin
    s1 = sha_pkg::ror(sw[14], 17) ^ sha_pkg::ror(sw[14], 19) ^ (sw[14] >> 10);
    s0 = sha_pkg::ror(sw[1], 7) ^ sha_pkg::ror(sw[1], 18) ^ (sw[1] >> 3);
    w  = (cmd.round < 6'd16) ? win : s1 + sw[9] + s0 + sw[0];
    a  = wv[0];
    e  = wv[4];
    t1 = wv[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
       + ((e & wv[5]) ^ (~e & wv[6])) + sha_pkg::RoundK[cmd.round] + w;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
       + ((a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]));
  end

  // The schedule window is a shift line: sw[15] is always the newest word.
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      for (int i = 0; i < 8; i++) hv[i] <= sha_pkg::Iv[i];
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) hv[i] <= hv[i] + wv[i];
    end else if (cmd.shift_out) begin
      for (int i = 0; i < 7; i++) hv[i] <= hv[i+1];
      hv[7] <= hv[0];
    end
    if (cmd.start_round) begin
      for (int i = 0; i < 8; i++) wv[i] <= hv[i];
    end else if (cmd.round_en) begin
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) sw[i] <= sw[i+1];
      sw[15] <= w;
    end
  end

  assign h0 = hv[0];

endmodule

// File: src/sha_ctrl.sv
module sha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              in_has,
  input  logic              in_end,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_index,
  output sha_pkg::sha_cmd_t cmd,
  output sha_pkg::word_t    win
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_ROUND = 6'b000100,
    S_FOLD  = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] buf_mem [16];
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [63:0] total;
  logic [5:0]  round;
  logic [2:0]  idx;
  logic        finishing;  // Message end seen; padding still to do.
  logic        pad_two;    // Building the second padding block (length only).
  logic        last_blk;   // Block in flight is the final one.
  logic [5:0]  pfill;
  logic [3:0]  rd_idx;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_index = idx;

  // The word for the next round is fetched ahead into a register.
  assign rd_idx = (state == S_ROUND) ? round[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    win <= buf_mem[rd_idx];
  end

  always_comb begin
    cmd = '0;
    cmd.round       = round;
    cmd.load_init   = rst || (state == S_OUT && out_ready && idx == 3'd7);
    cmd.start_round = (state == S_START);
    cmd.round_en    = (state == S_ROUND);
    cmd.fold        = (state == S_FOLD);
    cmd.shift_out   = (state == S_OUT && out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; bits <= '0; round <= '0; idx <= '0;
      finishing <= 1'b0; pad_two <= 1'b0; last_blk <= 1'b0; total <= '0; pfill <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_has) begin
              buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= in_byte;
              fill <= fill + 6'd1;
            end
            finishing <= in_end;
            total <= bits + {55'd0, fill + 6'(in_has), 3'd0};
            pfill <= fill + 6'(in_has);
            if (in_has && fill == 6'd63) begin
              state <= S_START; last_blk <= 1'b0; bits <= bits + 64'd512;
              total <= bits + 64'd512;
              pfill <= '0;
            end else if (in_end) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Build padding one byte a cycle; the length always lands in bytes 56..63.
          if (!pad_two && pfill == fill)
            buf_mem[pfill[5:2]][{~pfill[1:0], 3'b000} +: 8] <= 8'h80;
          else if (pfill >= 6'd56 && (pad_two || fill < 6'd56))
            buf_mem[pfill[5:2]][{~pfill[1:0], 3'b000} +: 8] <=
              total[{~pfill[2:0], 3'b000} +: 8];
          else
            buf_mem[pfill[5:2]][{~pfill[1:0], 3'b000} +: 8] <= 8'h00;
          pfill <= pfill + 6'd1;
          if (pfill == 6'd63) begin
            state <= S_START;
            last_blk <= pad_two || fill < 6'd56;
            pad_two <= !pad_two && fill >= 6'd56;
          end
        end
        S_START: begin
          round <= '0; state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          fill <= '0;
          if (last_blk && finishing) begin
            state <= S_OUT; idx <= '0;
          end else if (finishing) begin
            state <= S_PAD; pfill <= '0;
            if (!pad_two) begin
              fill <= '0;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              state <= S_IDLE; finishing <= 1'b0; pad_two <= 1'b0;
              bits <= '0; fill <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("output and input open together");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 6'd63) |=> state == S_FOLD)
    else $error("round count missed fold");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && idx == 3'd7) |=> state == S_IDLE && bits == '0)
    else $error("no reinit after digest");

endmodule

// File: src/sha256_hasher.sv
// SHA-256 hasher, one message byte per input beat.
// s_axis_tdata carries msg_byte; s_axis_tuser is {end_of_message, has_byte}.
// A beat with has_byte low and end_of_message low does nothing.
// Every 64th byte starts a compression of 64 rounds, one round per cycle,
// during which s_axis_tready is low; other bytes without end_of_message leave it high.
// An end_of_message beat pads the message in the byte buffer, one byte per
// cycle from the fill point to byte 63, then compresses; when the length does
// not fit, a second padding block and compression follow.
// The digest then leaves on m_axis as eight beats, H0 first; tuser holds the
// word index and tlast marks the eighth word. A stalled receiver holds the
// current word; no input is taken until all eight words are gone.
// After the digest the state returns to the initial hash values.
// The rate is set by the single round unit shared across all 64 rounds.
// Reset (rst, synchronous) loads the initial hash values and clears counts;
// it needs no clearing pass.
module sha256_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic [1:0]  s_axis_tuser,   // [0] has_byte, [1] end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::word_t    win;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .in_byte(s_axis_tdata), .in_has(s_axis_tuser[0]), .in_end(s_axis_tuser[1]),
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_index(m_axis_tuser), .cmd(cmd), .win(win)
  );

  sha_datapath u_dp (.clk(clk), .cmd(cmd), .win(win), .h0(m_axis_tdata));

  assign m_axis_tlast = (m_axis_tuser == 3'd7);

endmodule
